### hw/rtl/wbps_pkg.sv
// shared types and constants for the wildcard byte pattern scanner
package wbps_pkg;

  // default number of pattern cells
  localparam int unsigned PATTERN_MAX_DEF = 64;

  // field widths fixed by the interface
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned PIDX_W    = 6;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned TALLY_W   = 4;

  // match count saturation
  localparam logic [TALLY_W-1:0] TALLY_SAT = 4'd9;

  // request codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 3'd0,
    CMD_SEARCH  = 3'd1,
    CMD_SECTION = 3'd2,
    CMD_SCAN    = 3'd3,
    CMD_REPORT  = 3'd4
  } cmd_e;

  // control from the request decode to the match tally
  typedef struct packed {
    logic clear;  // new search
    logic hit;    // a full match ends at the current byte
  } tally_ctrl_t;

endpackage

### hw/rtl/wbps_cell.sv
// one pattern cell: stored entry plus its partial-match bit
module wbps_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  logic [7:0] wr_byte_i,
  input  logic       wr_wild_i,
  input  logic       shift_en_i,
  input  logic       clear_i,
  input  logic [7:0] data_byte_i,
  input  logic       prev_bit_i,
  output logic       bit_d_o,
  output logic       bit_q_o
);
  import wbps_pkg::*;

  logic [7:0] entry_byte_q;
  logic       entry_wild_q;
  logic       bit_q;
  logic       bit_d;

  // pattern entry storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_byte_q <= wr_byte_i;
      entry_wild_q <= wr_wild_i;
    end
  end

  // partial match extends the neighbor's when this entry matches
  always_comb begin
    bit_d = prev_bit_i && (entry_wild_q || (entry_byte_q == data_byte_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (clear_i) begin
      bit_q <= 1'b0;
    end else if (shift_en_i) begin
      bit_q <= bit_d;
    end
  end

  assign bit_d_o = bit_d;
  assign bit_q_o = bit_q;

endmodule

### hw/rtl/wbps_tally.sv
// match count, first match address and found flag of the current search
module wbps_tally (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wbps_pkg::tally_ctrl_t         ctrl_i,
  input  logic [wbps_pkg::ADDR_W-1:0]   start_addr_i,
  output logic                          any_o,
  output logic [wbps_pkg::TALLY_W-1:0]  tally_o,
  output logic [wbps_pkg::ADDR_W-1:0]   first_addr_o
);
  import wbps_pkg::*;

  logic               any_q, any_d;
  logic [TALLY_W-1:0] tally_q, tally_d;
  logic [ADDR_W-1:0]  first_q, first_d;

  // count matches until saturation, keep the first start address
  always_comb begin
    any_d   = any_q;
    tally_d = tally_q;
    first_d = first_q;
    if (ctrl_i.clear) begin
      any_d   = 1'b0;
      tally_d = '0;
      first_d = '0;
    end else if (ctrl_i.hit && (tally_q < TALLY_SAT)) begin
      if (!any_q) begin
        any_d   = 1'b1;
        first_d = start_addr_i;
      end
      tally_d = tally_q + TALLY_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q   <= 1'b0;
      tally_q <= '0;
      first_q <= '0;
    end else begin
      any_q   <= any_d;
      tally_q <= tally_d;
      first_q <= first_d;
    end
  end

  assign any_o        = any_q;
  assign tally_o      = tally_q;
  assign first_addr_o = first_q;

endmodule

### hw/rtl/wildcard_byte_pattern_scan.sv
// top level of the wildcard byte pattern scanner: cell chain, tally, result register
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   cmd, pattern_index, pattern_byte,
//                                                wildcard_req, data_byte, byte_address
//   out       output     out_valid_o/out_ready_i found, match_count, first_address
//   cfg       input      cfg_we_i                cfg_wdata_i (pattern_length)
//
// one request per cycle: a scanned byte updates every cell's partial-match bit at once
// a report result appears in the output register the cycle after the request
// input stalls only while a report result is held and out_ready_i is low
// reset clears the partial bits, tally, result valid and sets pattern_length to 1
// pattern entries hold no reset value and must be written before use
module wildcard_byte_pattern_scan #(
  parameter int unsigned PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wbps_pkg::LEN_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wbps_pkg::CMD_W-1:0]     cmd_i,
  input  logic [wbps_pkg::PIDX_W-1:0]    pattern_index_i,
  input  logic [7:0]                     pattern_byte_i,
  input  logic                           wildcard_req_i,
  input  logic [7:0]                     data_byte_i,
  input  logic [wbps_pkg::ADDR_W-1:0]    byte_address_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           found_o,
  output logic [wbps_pkg::TALLY_W-1:0]   match_count_o,
  output logic [wbps_pkg::ADDR_W-1:0]    first_address_o
);
  import wbps_pkg::*;

  localparam int unsigned IdxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned NumW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CmpW = (NumW > LEN_W) ? NumW : LEN_W;
  localparam int unsigned SelW = (IdxW > PIDX_W) ? IdxW : PIDX_W;

  logic [LEN_W-1:0]       pattern_length_q;
  logic                   in_acc;
  logic                   do_write, do_search, do_section, do_scan, do_report;
  logic [CmpW-1:0]        len_ext, len_used;
  logic [IdxW-1:0]        last_idx;
  logic [PATTERN_MAX-1:0] bit_d, bit_q;
  logic                   hit;
  logic [ADDR_W-1:0]      start_addr;
  tally_ctrl_t            tally_ctrl;
  logic                   any_match;
  logic [TALLY_W-1:0]     tally;
  logic [ADDR_W-1:0]      first_addr;
  logic                   out_valid_q;
  logic                   found_q;
  logic [TALLY_W-1:0]     count_q;
  logic [ADDR_W-1:0]      addr_q;

  // pattern length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= LEN_W'(1);
    end else if (cfg_we_i) begin
      pattern_length_q <= cfg_wdata_i;
    end
  end

  // clamp length into 1..PATTERN_MAX
  always_comb begin
    len_ext = CmpW'(pattern_length_q);
    if (len_ext == '0) begin
      len_used = CmpW'(1);
    end else if (len_ext > CmpW'(PATTERN_MAX)) begin
      len_used = CmpW'(PATTERN_MAX);
    end else begin
      len_used = len_ext;
    end
    last_idx = IdxW'(len_used - CmpW'(1));
  end

  // request decode
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    do_write   = 1'b0;
    do_search  = 1'b0;
    do_section = 1'b0;
    do_scan    = 1'b0;
    do_report  = 1'b0;
    unique case (cmd_e'(cmd_i))
      CMD_WRITE:   do_write   = in_acc;
      CMD_SEARCH:  do_search  = in_acc;
      CMD_SECTION: do_section = in_acc;
      CMD_SCAN:    do_scan    = in_acc;
      CMD_REPORT:  do_report  = in_acc;
      default: ;
    endcase
  end

  // chain of pattern cells
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic prev_bit;
    logic wr_sel;
    if (j == 0) begin : g_head
      assign prev_bit = 1'b1;
    end else begin : g_link
      assign prev_bit = bit_q[j-1];
    end
    assign wr_sel = do_write && (SelW'(pattern_index_i) == SelW'(j));

    wbps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_en_i     (wr_sel),
      .wr_byte_i   (pattern_byte_i),
      .wr_wild_i   (wildcard_req_i),
      .shift_en_i  (do_scan),
      .clear_i     (do_search || do_section),
      .data_byte_i (data_byte_i),
      .prev_bit_i  (prev_bit),
      .bit_d_o     (bit_d[j]),
      .bit_q_o     (bit_q[j])
    );
  end

  // full match ends at this byte when the last used cell matches
  assign hit        = do_scan && bit_d[last_idx];
  assign start_addr = byte_address_i - ADDR_W'(last_idx);

  assign tally_ctrl.clear = do_search;
  assign tally_ctrl.hit   = hit;

  wbps_tally u_tally (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (tally_ctrl),
    .start_addr_i (start_addr),
    .any_o        (any_match),
    .tally_o      (tally),
    .first_addr_o (first_addr)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_report) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_report) begin
      found_q <= any_match;
      count_q <= tally;
      addr_q  <= any_match ? first_addr : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign match_count_o   = count_q;
  assign first_address_o = addr_q;

endmodule
